>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/rar_pkg.sv
// Package: widths, operation codes and controller command/status types.
package rar_pkg;
	localparam int OperandWidth = 32;
	localparam int MagWidth = 64;
	localparam int CntWidth = 7;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
		OP_NEG = 3'd4, OP_INC = 3'd5, OP_DEC = 3'd6, OP_RED = 3'd7
	} op_t;

	typedef struct packed {
		logic load;      // capture operands, form products
		logic combine;   // form raw numerator and denominator
		logic gcd_start; // begin Euclid
		logic gcd_step;  // one remainder bit step
		logic gcd_swap;  // finish one remainder: p<=q, q<=r
		logic div_start; // begin exact divisions
		logic div_step;  // one quotient bit of both divisions
		logic finish;    // latch result into output register
	} cmd_t;

	typedef struct packed {
		logic q_zero;    // Euclid divisor is zero
		logic cnt_done;  // bit counter reached end
		logic skip;      // no reduction needed
	} status_t;
endpackage

>>> rtl/core/rar_if.sv
// Input and output valid/ready channel interfaces of the rational arithmetic unit.
interface rar_in_if ();
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] a_num;
	logic [31:0] a_den;
	logic [31:0] b_num;
	logic [31:0] b_den;
	modport source (output valid, output kind, output a_num, output a_den,
		output b_num, output b_den, input ready);
	modport sink (input valid, input kind, input a_num, input a_den,
		input b_num, input b_den, output ready);
endinterface

interface rar_out_if ();
	logic        valid;
	logic        ready;
	logic [63:0] res_num;
	logic [63:0] res_den;
	logic        error;
	modport source (output valid, output res_num, output res_den, output error,
		input ready);
	modport sink (input valid, input res_num, input res_den, input error,
		output ready);
endinterface

>>> rtl/core/rar_datapath.sv
// Datapath: operand products, signed combine, shift-subtract Euclid and division.
`include "assert_macros.svh"
module rar_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rar_pkg::cmd_t               cmd,
	output rar_pkg::status_t            status,
	input  logic [2:0]                  kind,
	input  logic [31:0]                 a_num,
	input  logic [31:0]                 a_den,
	input  logic [31:0]                 b_num,
	input  logic [31:0]                 b_den,
	output logic [63:0]                 res_num,
	output logic [63:0]                 res_den,
	output logic                        error
);
	localparam int W = rar_pkg::OperandWidth;
	localparam int M = rar_pkg::MagWidth;

	function automatic logic [W:0] mag_of(input logic [31:0] raw);
		logic [W-1:0] v;
		begin
			v = raw[W-1:0];
			mag_of = v[W-1] ? {1'b1, (~v) + {{(W-1){1'b0}}, 1'b1}} : {1'b0, v};
			mag_of[W] = v[W-1];
		end
	endfunction
	// mag_of returns {sign, magnitude}; magnitude of most negative is 2^(W-1)

	logic [W:0] an, ad, bn, bd;
	logic [2:0] kind_q;
	logic       p1_neg_q, p2_neg_q, d_neg_q;
	logic [M-1:0] p1_q, p2_q, dm_q;
	logic       n_neg_q, dd_neg_q;
	logic [M-1:0] nm_q, dmg_q;
	logic [M-1:0] gp_q, gq_q, rem_q;
	logic [rar_pkg::CntWidth-1:0] cnt_q;
	logic [M-1:0] qn_q, rn_q, qd_q, rd_q;

	always_comb begin
		an = mag_of(a_num);
		ad = mag_of(a_den);
		bn = mag_of(b_num);
		bd = mag_of(b_den);
	end

	// Operand selection for the two numerator products and the denominator product per kind
	logic [W-1:0] x1, y1, x2, y2, x3, y3;
	logic s1, s2, s3;
	always_comb begin
		x1 = an[W-1:0]; y1 = bd[W-1:0]; s1 = an[W] ^ bd[W];
		x2 = bn[W-1:0]; y2 = ad[W-1:0]; s2 = bn[W] ^ ad[W];
		x3 = ad[W-1:0]; y3 = bd[W-1:0]; s3 = ad[W] ^ bd[W];
		case (rar_pkg::op_t'(kind))
			rar_pkg::OP_MUL: begin
				y1 = bn[W-1:0]; s1 = an[W] ^ bn[W];
			end
			rar_pkg::OP_DIV: begin
				y3 = bn[W-1:0]; s3 = ad[W] ^ bn[W];
			end
			rar_pkg::OP_NEG, rar_pkg::OP_INC, rar_pkg::OP_DEC, rar_pkg::OP_RED: begin
				y1 = {{(W-1){1'b0}}, 1'b1}; s1 = an[W];
				x2 = {{(W-1){1'b0}}, 1'b1}; s2 = ad[W];
				y3 = {{(W-1){1'b0}}, 1'b1}; s3 = ad[W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			p1_q <= M'({{(M-W){1'b0}}, x1} * {{(M-W){1'b0}}, y1});
			p2_q <= M'({{(M-W){1'b0}}, x2} * {{(M-W){1'b0}}, y2});
			dm_q <= M'({{(M-W){1'b0}}, x3} * {{(M-W){1'b0}}, y3});
			p1_neg_q <= s1;
			p2_neg_q <= s2;
			d_neg_q <= s3;
		end
	end

	// Signed-magnitude combine of the two products
	logic        sub2, sn;
	logic [M-1:0] sm;
	always_comb begin
		sub2 = kind_q inside {rar_pkg::OP_SUB, rar_pkg::OP_DEC};
		sn = p1_neg_q;
		sm = p1_q;
		if (kind_q inside {rar_pkg::OP_ADD, rar_pkg::OP_SUB, rar_pkg::OP_INC,
		    rar_pkg::OP_DEC}) begin
			if (p1_neg_q == (p2_neg_q ^ sub2)) begin
				sm = p1_q + p2_q;
			end else if (p1_q >= p2_q) begin
				sm = p1_q - p2_q;
			end else begin
				sm = p2_q - p1_q;
				sn = p2_neg_q ^ sub2;
			end
		end else if (kind_q == rar_pkg::OP_NEG) begin
			sn = ~p1_neg_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			nm_q <= sm;
			n_neg_q <= sn & (sm != '0);
			dmg_q <= dm_q;
			dd_neg_q <= d_neg_q & (dm_q != '0);
		end
	end

	// Euclid: rem = gp mod gq bit-serially (restoring), then gp<=gq, gq<=rem
	logic [M:0] trial;
	always_comb trial = {rem_q, gp_q[M-1]} - {1'b0, gq_q};

	always_ff @(posedge clk) begin
		if (cmd.gcd_start) begin
			gp_q <= nm_q;
			gq_q <= dmg_q;
			rem_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!trial[M]) rem_q <= trial[M-1:0];
			else rem_q <= {rem_q[M-2:0], gp_q[M-1]};
			gp_q <= {gp_q[M-2:0], 1'b0};
		end else if (cmd.gcd_swap) begin
			gp_q <= gq_q;
			gq_q <= rem_q;
			rem_q <= '0;
		end else if (cmd.div_start) begin
			qn_q <= nm_q;
			qd_q <= dmg_q;
			rn_q <= '0;
			rd_q <= '0;
		end else if (cmd.div_step) begin
			logic [M:0] tn, td;
			tn = {rn_q, qn_q[M-1]} - {1'b0, gp_q};
			td = {rd_q, qd_q[M-1]} - {1'b0, gp_q};
			rn_q <= tn[M] ? {rn_q[M-2:0], qn_q[M-1]} : tn[M-1:0];
			rd_q <= td[M] ? {rd_q[M-2:0], qd_q[M-1]} : td[M-1:0];
			qn_q <= {qn_q[M-2:0], ~tn[M]};
			qd_q <= {qd_q[M-2:0], ~td[M]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.gcd_start || cmd.gcd_swap || cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.gcd_step || cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		status.q_zero = (gq_q == '0);
		status.cnt_done = (cnt_q == rar_pkg::CntWidth'(M - 1));
		status.skip = (kind_q == rar_pkg::OP_NEG) || ((nm_q == '0) && (dmg_q == '0));
	end

	// The output takes the quotient registers when reduction ran, else the raw values
	logic skip_q;
	always_ff @(posedge clk) begin
		if (cmd.div_start) skip_q <= 1'b0;
		else if (cmd.combine) skip_q <= 1'b1;
	end

	logic [M-1:0] fn, fd;
	always_comb begin
		fn = skip_q ? nm_q : qn_q;
		fd = skip_q ? dmg_q : qd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_num <= n_neg_q ? ('0 - fn) : fn;
			res_den <= dd_neg_q ? ('0 - fd) : fd;
			error <= (dmg_q == '0);
		end
	end

	`ASSERT_IMPLY(a_step_excl, clk, arst_n, cmd.gcd_step, !cmd.div_step && !cmd.load)
	`ASSERT_IMPLY(a_swap_excl, clk, arst_n, cmd.gcd_swap, !cmd.gcd_step)
	`ASSERT_NEXT(a_start_cnt, clk, arst_n, cmd.gcd_start, cnt_q == '0)
endmodule

>>> rtl/core/rar_ctrl.sv
// Controller: sequences load, combine, Euclid, exact division and output.
`include "assert_macros.svh"
module rar_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rar_pkg::status_t status,
	output rar_pkg::cmd_t    cmd
);
	typedef enum logic [8:0] {
		S_IDLE   = 9'b0_0000_0001, S_COMB  = 9'b0_0000_0010, S_DECIDE = 9'b0_0000_0100,
		S_GTEST  = 9'b0_0000_1000, S_GSTEP = 9'b0_0001_0000, S_GSWAP  = 9'b0_0010_0000,
		S_DSTART = 9'b0_0100_0000, S_DSTEP = 9'b0_1000_0000, S_FIN    = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// A new item may start in idle once the output register is empty or is being emptied.
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = S_COMB;
				end
			end
			S_COMB: begin
				cmd.combine = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.skip) begin
					state_d = S_FIN;
				end else begin
					cmd.gcd_start = 1'b1;
					state_d = S_GTEST;
				end
			end
			S_GTEST: begin
				// test the divisor before the next remainder
				if (status.q_zero) begin
					state_d = S_DSTART;
				end else begin
					state_d = S_GSTEP;
				end
			end
			S_GSTEP: begin
				cmd.gcd_step = 1'b1;
				if (status.cnt_done) state_d = S_GSWAP;
			end
			S_GSWAP: begin
				// finishing a remainder swaps the pair
				cmd.gcd_swap = 1'b1;
				state_d = S_GTEST;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.div_step = 1'b1;
				if (status.cnt_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`ASSERT_IMPLY(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`ASSERT_NEXT(a_fin_valid, clk, arst_n, cmd.finish, out_valid_q)
	`ASSERT_IMPLY(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
endmodule

>>> rtl/core/rational_arith_reduce_unit.sv
// Top level: rational arithmetic with GCD reduction.
//
// Usage: one input channel (in_ch) carries kind and two fractions a, b; one output
// channel (out_ch) carries res_num, res_den and error. Both use valid/ready; a
// transfer happens on a rising edge with valid and ready high.
// From the input transfer to raising out valid, negate and 0/0 go through combine,
// decide and the write of the output register. Every other item runs, between
// decide and that write, k Euclid remainders and then the exact division; each
// remainder is 64 shift-subtract steps, a swap and a divisor test, and the exact
// division of both parts by the GCD is a start state plus 64 steps. k stays below
// about 92 for 64-bit magnitudes.
// One item is in flight at a time: the next input transfer is taken in the cycle
// after the result is written, once the output register is free or is being
// emptied in the same cycle.
// A stalled receiver holds the result and stops the block in idle, taking no new input.
// Reset (arst_n low) clears the controller and drops any pending result.
// Error is high when the result denominator is zero; 0/0 is passed unchanged.
module rational_arith_reduce_unit (
	input logic clk,
	input logic arst_n,
	rar_in_if.sink   in_ch,
	rar_out_if.source out_ch
);
	rar_pkg::cmd_t    cmd;
	rar_pkg::status_t status;

	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rar_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.kind    (in_ch.kind),
		.a_num   (in_ch.a_num),
		.a_den   (in_ch.a_den),
		.b_num   (in_ch.b_num),
		.b_den   (in_ch.b_den),
		.res_num (out_ch.res_num),
		.res_den (out_ch.res_den),
		.error   (out_ch.error)
	);
endmodule
